// ===== rtl/ocq_pkg.sv =====
// ----------------------------------------------------------------------------
// Octree occupancy package
// Shared constants, register codes and the control and status bundles between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package ocq_pkg;

    localparam int NODE_POOL_DEF  = 4096;
    localparam int MAX_LEVELS_DEF = 16;

    localparam int POS_W     = 32;
    localparam int CTR_W     = 34;
    localparam int STEP_W    = 31;
    localparam int RAD_W     = 5;
    localparam int MLVL_W    = 5;
    localparam int LEAF_W    = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [RAD_W-1:0]  RADIUS_RST    = RAD_W'(20);
    localparam logic [MLVL_W-1:0] MAX_LEVEL_RST = MLVL_W'(10);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_RADIUS   = 3'd3,
        CFG_MAX_LVL  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic load;
        logic read;
        logic decide;
        logic finish;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic lvl_done;
        logic fresh;
        logic stop;
    } status_t;

endpackage

// ===== rtl/ocq_ram.sv =====
// ----------------------------------------------------------------------------
// Single-port RAM
// One address per cycle, synchronous write, registered read data.
// ----------------------------------------------------------------------------
module ocq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ocq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Octree occupancy controller
// Sequences the descent of one item: row read, octant decision, result hand-off.
// ----------------------------------------------------------------------------
module ocq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  ocq_pkg::status_t status,
    output ocq_pkg::cmd_t    cmd
);
    import ocq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DECIDE,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.read   = !status.lvl_done && !status.fresh;
                state_next = status.lvl_done ? S_FINISH : S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.stop ? S_FINISH : S_CHECK;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/ocq_dpath.sv =====
// ----------------------------------------------------------------------------
// Octree occupancy datapath
// Configuration, moving centre, node pool, child-link row memory and result.
// ----------------------------------------------------------------------------
module ocq_dpath #(
    parameter int NODE_POOL  = ocq_pkg::NODE_POOL_DEF,
    parameter int MAX_LEVELS = ocq_pkg::MAX_LEVELS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ocq_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ocq_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  req_type,
    input  logic signed [ocq_pkg::POS_W-1:0]      pos_x,
    input  logic signed [ocq_pkg::POS_W-1:0]      pos_y,
    input  logic signed [ocq_pkg::POS_W-1:0]      pos_z,
    output logic                                  occupied,
    output logic [ocq_pkg::LEAF_W-1:0]            leaf_index,
    output logic                                  pool_full,
    input  ocq_pkg::cmd_t                         cmd,
    output ocq_pkg::status_t                      status
);
    import ocq_pkg::*;

    localparam int IDX_W  = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
    localparam int CNT_W  = $clog2(NODE_POOL + 1);
    localparam int LINK_W = IDX_W + 1;
    localparam int ROW_W  = 8 * LINK_W;
    localparam int LVL_W  = $clog2(MAX_LEVELS + 1);

    logic signed [POS_W-1:0] cfg_cx_reg;
    logic signed [POS_W-1:0] cfg_cy_reg;
    logic signed [POS_W-1:0] cfg_cz_reg;
    logic [RAD_W-1:0]        radius_reg;
    logic [MLVL_W-1:0]       max_level_reg;

    logic                    query_reg;
    logic signed [POS_W-1:0] px_reg;
    logic signed [POS_W-1:0] py_reg;
    logic signed [POS_W-1:0] pz_reg;
    logic signed [CTR_W-1:0] cx_reg;
    logic signed [CTR_W-1:0] cy_reg;
    logic signed [CTR_W-1:0] cz_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [LVL_W-1:0]        levels_reg;
    logic [LVL_W-1:0]        lvl_reg;
    logic [IDX_W-1:0]        node_reg;
    logic                    fresh_reg;
    logic                    fail_reg;
    logic                    full_reg;
    logic [CNT_W-1:0]        node_count_reg;
    logic                    root_init_reg;
    logic                    occupied_reg;
    logic [LEAF_W-1:0]       leaf_reg;
    logic                    pool_full_reg;

    logic [LVL_W-1:0]        levels_next;
    logic [STEP_W-1:0]       step_init;
    logic signed [CTR_W-1:0] px_ext;
    logic signed [CTR_W-1:0] py_ext;
    logic signed [CTR_W-1:0] pz_ext;
    logic signed [CTR_W-1:0] step_ext;
    logic                    gx;
    logic                    gy;
    logic                    gz;
    logic [2:0]              oct;
    logic [ROW_W-1:0]        rd_data;
    logic [ROW_W-1:0]        row_cur;
    logic [LINK_W-1:0]       links [8];
    logic [LINK_W-1:0]       link_sel;
    logic                    link_valid;
    logic                    full_now;
    logic                    alloc;
    logic [IDX_W-1:0]        fresh_idx;
    logic [ROW_W-1:0]        row_new;
    logic                    ram_we;
    logic [ROW_W-1:0]        ram_wdata;
    logic [LEAF_W+IDX_W-1:0] leaf_wide;

    assign levels_next = (int'(max_level_reg) < MAX_LEVELS) ? LVL_W'(max_level_reg)
                                                            : LVL_W'(MAX_LEVELS);
    assign step_init   = (radius_reg == '0) ? '0
                                            : (STEP_W'(1) << (radius_reg - RAD_W'(1)));

    assign px_ext   = CTR_W'(px_reg);
    assign py_ext   = CTR_W'(py_reg);
    assign pz_ext   = CTR_W'(pz_reg);
    assign step_ext = $signed(CTR_W'(step_reg));

    assign gx  = px_ext > cx_reg;
    assign gy  = py_ext > cy_reg;
    assign gz  = pz_ext > cz_reg;
    assign oct = {!gx, !gy, !gz};

    assign row_cur = fresh_reg ? '0 : rd_data;

    for (genvar k = 0; k < 8; k++)
    begin : g_links
        assign links[k] = row_cur[k*LINK_W +: LINK_W];
    end

    assign link_sel   = links[oct];
    assign link_valid = link_sel[LINK_W-1];
    assign full_now   = (node_count_reg == CNT_W'(NODE_POOL));
    assign alloc      = !link_valid && !query_reg && !full_now;
    assign fresh_idx  = node_count_reg[IDX_W-1:0];

    always_comb
    begin
        row_new = row_cur;
        for (int k = 0; k < 8; k++)
        begin
            if (oct == 3'(k))
            begin
                row_new[k*LINK_W +: LINK_W] = {1'b1, fresh_idx};
            end
        end
    end

    assign ram_we    = (cmd.decide && alloc) || (cmd.finish && fresh_reg && !query_reg);
    assign ram_wdata = cmd.finish ? '0 : row_new;

    ocq_ram #(
        .WIDTH (ROW_W),
        .DEPTH (1 << IDX_W)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (cmd.read),
        .addr  (node_reg),
        .wdata (ram_wdata),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_cx_reg     <= '0;
            cfg_cy_reg     <= '0;
            cfg_cz_reg     <= '0;
            radius_reg     <= RADIUS_RST;
            max_level_reg  <= MAX_LEVEL_RST;
            node_count_reg <= CNT_W'(1);
            root_init_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CENTER_X: cfg_cx_reg    <= $signed(cfg_data);
                    CFG_CENTER_Y: cfg_cy_reg    <= $signed(cfg_data);
                    CFG_CENTER_Z: cfg_cz_reg    <= $signed(cfg_data);
                    CFG_RADIUS:   radius_reg    <= cfg_data[RAD_W-1:0];
                    CFG_MAX_LVL:  max_level_reg <= cfg_data[MLVL_W-1:0];
                    default:      ;
                endcase
            end
            if (cmd.decide && alloc)
            begin
                node_count_reg <= node_count_reg + CNT_W'(1);
            end
            if (ram_we && (node_reg == '0))
            begin
                root_init_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            query_reg  <= req_type;
            px_reg     <= pos_x;
            py_reg     <= pos_y;
            pz_reg     <= pos_z;
            cx_reg     <= CTR_W'(cfg_cx_reg);
            cy_reg     <= CTR_W'(cfg_cy_reg);
            cz_reg     <= CTR_W'(cfg_cz_reg);
            step_reg   <= step_init;
            levels_reg <= levels_next;
            lvl_reg    <= '0;
            node_reg   <= '0;
            fresh_reg  <= !root_init_reg;
            fail_reg   <= 1'b0;
            full_reg   <= 1'b0;
        end
        else if (cmd.decide)
        begin
            if (link_valid || alloc)
            begin
                cx_reg    <= gx ? cx_reg + step_ext : cx_reg - step_ext;
                cy_reg    <= gy ? cy_reg + step_ext : cy_reg - step_ext;
                cz_reg    <= gz ? cz_reg + step_ext : cz_reg - step_ext;
                step_reg  <= step_reg >> 1;
                lvl_reg   <= lvl_reg + LVL_W'(1);
                node_reg  <= link_valid ? link_sel[IDX_W-1:0] : fresh_idx;
                fresh_reg <= alloc;
            end
            else
            begin
                fail_reg <= 1'b1;
                full_reg <= !query_reg;
            end
        end
        if (cmd.capture)
        begin
            occupied_reg  <= !fail_reg;
            leaf_reg      <= fail_reg ? '0 : leaf_wide[LEAF_W-1:0];
            pool_full_reg <= full_reg;
        end
    end

    assign leaf_wide = {{LEAF_W{1'b0}}, node_reg};

    assign status.lvl_done = (lvl_reg == levels_reg);
    assign status.fresh    = fresh_reg;
    assign status.stop     = !link_valid && !alloc;

    assign occupied   = occupied_reg;
    assign leaf_index = leaf_reg;
    assign pool_full  = pool_full_reg;

endmodule

// ===== rtl/octree_occupancy_insert_query.sv =====
// ----------------------------------------------------------------------------
// Octree occupancy insert and query
// Sparse voxel octree over a node pool with an occupy and a point query.
// ----------------------------------------------------------------------------
// An item is accepted in the idle state and then passes a check state and a
// decision state for every level it descends: a row read of the single-port
// child-link memory, which is skipped for a node that the same item has just
// allocated and whose row is known to be empty, and the octant decision. A
// check state that finds the last level reached ends the descent, and a finish
// state hands the result to the output register. An item that stops at a level,
// a query that finds no link or an occupy that finds the pool exhausted, goes
// from its decision state straight to the finish state. With max_level at its
// reset value of ten an item descends at most ten levels. A result waits in the
// finish state while the previous one still waits in the output register.
// One item is worked on at a time; the next is accepted while a finished result
// still waits in the output register. The child-link memory holds one row of
// eight links per node and needs no clearing pass after reset: a node's row is
// written when the node is first given a child or when the item that allocated
// it ends.
// ----------------------------------------------------------------------------
module octree_occupancy_insert_query #(
    parameter int NODE_POOL  = ocq_pkg::NODE_POOL_DEF,
    parameter int MAX_LEVELS = ocq_pkg::MAX_LEVELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ocq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ocq_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic signed [ocq_pkg::POS_W-1:0]  pos_x,
    input  logic signed [ocq_pkg::POS_W-1:0]  pos_y,
    input  logic signed [ocq_pkg::POS_W-1:0]  pos_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              occupied,
    output logic [ocq_pkg::LEAF_W-1:0]        leaf_index,
    output logic                              pool_full
);
    import ocq_pkg::*;

    cmd_t    cmd;
    status_t status;

    ocq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ocq_dpath #(
        .NODE_POOL  (NODE_POOL),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_type   (req_type),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .occupied   (occupied),
        .leaf_index (leaf_index),
        .pool_full  (pool_full),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

// ===== test/ocq_test_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octree occupancy test package
// Request kinds shared by the stimulus side and the result checker.
// ----------------------------------------------------------------------------
package ocq_test_pkg;

    typedef enum logic {
        REQ_OCCUPY = 1'b0,
        REQ_QUERY  = 1'b1
    } req_kind_t;

endpackage

// ===== test/octree_occupancy_insert_query_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octree occupancy result checker
// Watches the register port and both item channels, keeps its own copy of the
// node pool and the field settings, predicts the result of every accepted
// request and compares each delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module octree_occupancy_insert_query_check
    import ocq_pkg::*;
    import ocq_test_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic                     req_type,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic signed [POS_W-1:0]  pos_z,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic                     occupied,
    input  logic [LEAF_W-1:0]        leaf_index,
    input  logic                     pool_full,
    input  logic                     drained,
    output int                       errors
);

    localparam int LINK_SLOTS  = NODE_POOL_DEF * 8;
    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        logic              occupied;
        logic [LEAF_W-1:0] leaf;
        logic              full;
    } leaf_result_t;

    logic [LEAF_W:0]         child_links [LINK_SLOTS];
    int unsigned             nodes_used;
    logic signed [POS_W-1:0] centre_x;
    logic signed [POS_W-1:0] centre_y;
    logic signed [POS_W-1:0] centre_z;
    logic [RAD_W-1:0]        radius_log2;
    logic [MLVL_W-1:0]       depth;
    leaf_result_t            awaited[$];
    logic                    leftovers_checked;

    task automatic note_error(input string msg);
        if (errors < PRINT_LIMIT)
        begin
            $display("%0t ns: %s", $time, msg);
        end
        errors++;
    endtask

    function automatic leaf_result_t descend(input logic query,
                                             input logic signed [POS_W-1:0] px,
                                             input logic signed [POS_W-1:0] py,
                                             input logic signed [POS_W-1:0] pz);
        logic signed [CTR_W-1:0] wx;
        logic signed [CTR_W-1:0] wy;
        logic signed [CTR_W-1:0] wz;
        logic signed [CTR_W-1:0] cx;
        logic signed [CTR_W-1:0] cy;
        logic signed [CTR_W-1:0] cz;
        logic signed [CTR_W-1:0] step;
        logic [2:0]              oct;
        logic [LEAF_W:0]         link;
        int unsigned             node;
        int unsigned             slot;
        int                      levels;
        leaf_result_t            res;
        wx = px;
        wy = py;
        wz = pz;
        cx = centre_x;
        cy = centre_y;
        cz = centre_z;
        levels = (int'(depth) < MAX_LEVELS_DEF) ? int'(depth) : MAX_LEVELS_DEF;
        node = 0;
        res = '{occupied: 1'b1, leaf: '0, full: 1'b0};
        for (int lv = 0; lv < levels; lv++)
        begin
            step = '0;
            if (int'(radius_log2) >= lv + 1)
            begin
                step = CTR_W'(1) << (int'(radius_log2) - 1 - lv);
            end
            oct = {(wx > cx) ? 1'b0 : 1'b1, (wy > cy) ? 1'b0 : 1'b1, (wz > cz) ? 1'b0 : 1'b1};
            slot = node * 8 + oct;
            link = child_links[slot];
            cx = (wx > cx) ? cx + step : cx - step;
            cy = (wy > cy) ? cy + step : cy - step;
            cz = (wz > cz) ? cz + step : cz - step;
            if (link[LEAF_W])
            begin
                node = link[LEAF_W-1:0];
            end
            else if (query)
            begin
                res.occupied = 1'b0;
                break;
            end
            else if (nodes_used >= NODE_POOL_DEF)
            begin
                res.occupied = 1'b0;
                res.full = 1'b1;
                break;
            end
            else
            begin
                child_links[slot] = {1'b1, LEAF_W'(nodes_used)};
                node = nodes_used;
                nodes_used++;
            end
        end
        if (res.occupied)
        begin
            res.leaf = node[LEAF_W-1:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        leaf_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < LINK_SLOTS; i++)
            begin
                child_links[i] = '0;
            end
            nodes_used = 1;
            centre_x = '0;
            centre_y = '0;
            centre_z = '0;
            radius_log2 = RADIUS_RST;
            depth = MAX_LEVEL_RST;
            awaited.delete();
            leftovers_checked = 1'b0;
            errors = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CENTER_X: centre_x = cfg_data;
                    CFG_CENTER_Y: centre_y = cfg_data;
                    CFG_CENTER_Z: centre_z = cfg_data;
                    CFG_RADIUS:   radius_log2 = cfg_data[RAD_W-1:0];
                    CFG_MAX_LVL:  depth = cfg_data[MLVL_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                awaited.insert(awaited.size(),
                               descend(req_type == REQ_QUERY, pos_x, pos_y, pos_z));
            end
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                begin
                    note_error("result item delivered with no request outstanding");
                end
                else
                begin
                    want = awaited.pop_front();
                    if (occupied !== want.occupied)
                    begin
                        note_error($sformatf("occupied is %b, expected %b",
                                             occupied, want.occupied));
                    end
                    if (leaf_index !== want.leaf)
                    begin
                        note_error($sformatf("leaf_index is %0d, expected %0d",
                                             leaf_index, want.leaf));
                    end
                    if (pool_full !== want.full)
                    begin
                        note_error($sformatf("pool_full is %b, expected %b",
                                             pool_full, want.full));
                    end
                end
            end
            if (drained && !leftovers_checked)
            begin
                leftovers_checked = 1'b1;
                if (awaited.size() != 0)
                begin
                    note_error($sformatf("%0d results never arrived", awaited.size()));
                end
            end
        end
    end

endmodule

// ===== test/octree_occupancy_insert_query_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octree occupancy insert and query testbench
// Drives occupy and query requests under several field settings, first a
// directed set around the corners, ties and a zero depth, then random items
// built mostly from revisited, nearby and centre-aligned points, with a phase
// that fills the node pool. Both channels idle at random; a separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module octree_occupancy_insert_query_test;
    import ocq_pkg::*;
    import ocq_test_pkg::*;

    localparam int          LIMIT      = 1000000;
    localparam int          SETTLE     = 40;
    localparam int          PHASES     = 7;
    localparam int          PER_PHASE  = 285;
    localparam int          KEEP       = 64;
    localparam logic [31:0] TOP_POS    = 32'h7fffffff;
    localparam logic [31:0] BOTTOM_NEG = 32'h80000000;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } point_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    req_type;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    out_valid;
    logic                    out_stall;
    logic                    occupied;
    logic [LEAF_W-1:0]       leaf_index;
    logic                    pool_full;
    logic                    drained;
    int                      fault_count;

    int unsigned sent_n;
    int unsigned got_n;
    int unsigned full_n;
    int unsigned cycles;
    int unsigned occupy_n;
    int unsigned query_n;
    int unsigned settings_n;
    int          tx_idle;
    int          rx_idle;
    logic [31:0] cur_cx;
    logic [31:0] cur_cy;
    logic [31:0] cur_cz;
    logic [4:0]  cur_rad;
    point_t      seen_points[$];

    octree_occupancy_insert_query dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .occupied   (occupied),
        .leaf_index (leaf_index),
        .pool_full  (pool_full)
    );

    octree_occupancy_insert_query_check leaf_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .occupied   (occupied),
        .leaf_index (leaf_index),
        .pool_full  (pool_full),
        .drained    (drained),
        .errors     (fault_count)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (in_valid && !in_stall)
        begin
            sent_n <= sent_n + 1;
        end
        if (out_valid && !out_stall)
        begin
            got_n <= got_n + 1;
            if (pool_full)
            begin
                full_n <= full_n + 1;
            end
        end
        if (cycles == LIMIT)
        begin
            $display("octree_occupancy_insert_query_test: done, errors");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < rx_idle);
    end

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (got_n != sent_n);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    task automatic set_field(input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] cz, input logic [4:0] rad,
                             input logic [4:0] lvls);
        wait_idle();
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_RADIUS, 32'(rad));
        write_reg(CFG_MAX_LVL, 32'(lvls));
        cfg_we <= 1'b0;
        cur_cx = cx;
        cur_cy = cy;
        cur_cz = cz;
        cur_rad = rad;
        settings_n++;
    endtask

    task automatic send(input req_kind_t kind, input logic [31:0] x,
                        input logic [31:0] y, input logic [31:0] z);
        int unsigned goal;
        point_t      pt;
        goal = sent_n + 1;
        while ($urandom_range(99) < tx_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        do
        begin
            @(negedge clk);
        end
        while (sent_n != goal);
        if (kind == REQ_OCCUPY)
        begin
            occupy_n++;
            pt = '{x: x, y: y, z: z};
            seen_points.insert(seen_points.size(), pt);
            if (seen_points.size() > KEEP)
            begin
                void'(seen_points.pop_front());
            end
        end
        else
        begin
            query_n++;
        end
    endtask

    // A coordinate that lands exactly on a centre the descent passes through,
    // so that the tie rule is exercised at some level.
    function automatic logic [31:0] on_centre(input logic [31:0] c);
        logic signed [CTR_W-1:0] p;
        int                      k;
        p = $signed(c);
        k = $urandom_range(MAX_LEVELS_DEF);
        for (int l = 0; l < k; l++)
        begin
            if (int'(cur_rad) >= l + 1)
            begin
                if ($urandom_range(1))
                begin
                    p = p + (CTR_W'(1) << (int'(cur_rad) - 1 - l));
                end
                else
                begin
                    p = p - (CTR_W'(1) << (int'(cur_rad) - 1 - l));
                end
            end
        end
        return p[31:0];
    endfunction

    task automatic random_request(input bit filling);
        int        mode;
        req_kind_t kind;
        point_t    pt;
        mode = $urandom_range(99);
        kind = $urandom_range(1) ? REQ_QUERY : REQ_OCCUPY;
        pt = '{x: $urandom, y: $urandom, z: $urandom};
        if (filling)
        begin
            kind = ($urandom_range(99) < 85) ? REQ_OCCUPY : REQ_QUERY;
        end
        else if (mode < 40 && seen_points.size() > 0)
        begin
            pt = seen_points[$urandom_range(seen_points.size() - 1)];
            kind = ($urandom_range(99) < 60) ? REQ_QUERY : REQ_OCCUPY;
        end
        else if (mode < 60 && seen_points.size() > 0)
        begin
            pt = seen_points[$urandom_range(seen_points.size() - 1)];
            pt.x = pt.x + 32'($urandom_range(255)) - 32'd128;
            pt.y = pt.y + 32'($urandom_range(255)) - 32'd128;
            pt.z = pt.z + 32'($urandom_range(255)) - 32'd128;
        end
        else if (mode < 80)
        begin
            pt = '{x: on_centre(cur_cx), y: on_centre(cur_cy), z: on_centre(cur_cz)};
        end
        send(kind, pt.x, pt.y, pt.z);
    endtask

    initial
    begin
        int random_n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = 1'b0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        out_stall = 1'b0;
        drained = 1'b0;
        sent_n = 0;
        got_n = 0;
        full_n = 0;
        cycles = 0;
        occupy_n = 0;
        query_n = 0;
        settings_n = 0;
        random_n = 0;
        tx_idle = 22;
        rx_idle = 79;
        cur_cx = '0;
        cur_cy = '0;
        cur_cz = '0;
        cur_rad = RADIUS_RST;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send(REQ_QUERY, '0, '0, '0);
        send(REQ_OCCUPY, '0, '0, '0);
        send(REQ_QUERY, '0, '0, '0);
        send(REQ_OCCUPY, '0, '0, '0);
        send(REQ_OCCUPY, TOP_POS, TOP_POS, TOP_POS);
        send(REQ_QUERY, TOP_POS, TOP_POS, TOP_POS);
        send(REQ_OCCUPY, BOTTOM_NEG, BOTTOM_NEG, BOTTOM_NEG);
        send(REQ_QUERY, BOTTOM_NEG, BOTTOM_NEG, BOTTOM_NEG);
        send(REQ_QUERY, TOP_POS, BOTTOM_NEG, '0);
        send(REQ_OCCUPY, 32'd1, 32'hffffffff, 32'd1);
        send(REQ_QUERY, 32'd1, 32'hffffffff, 32'd1);
        send(REQ_QUERY, '0, '0, 32'd1);

        // With no levels to descend the root itself is the leaf.
        set_field('0, '0, '0, RADIUS_RST, 5'd0);
        send(REQ_QUERY, $urandom, $urandom, $urandom);
        send(REQ_OCCUPY, $urandom, $urandom, $urandom);

        // Writes to unused register indexes must leave the field untouched.
        set_field('0, '0, '0, RADIUS_RST, MAX_LEVEL_RST);
        for (int i = CFG_MAX_LVL + 1; i < (1 << CFG_IDX_W); i++)
        begin
            write_reg(CFG_IDX_W'(i), $urandom);
        end
        cfg_we <= 1'b0;
        send(REQ_QUERY, '0, '0, '0);
        send(REQ_QUERY, TOP_POS, TOP_POS, TOP_POS);

        set_field('0, '0, '0, 5'd0, 5'd16);
        send(REQ_OCCUPY, 32'd5, 32'hfffffffb, '0);
        send(REQ_QUERY, 32'd5, 32'hfffffffb, '0);
        set_field(TOP_POS, BOTTOM_NEG, '0, 5'd30, 5'd16);
        send(REQ_OCCUPY, BOTTOM_NEG, TOP_POS, 32'h12345678);
        send(REQ_QUERY, BOTTOM_NEG, TOP_POS, 32'h12345678);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: set_field('0, '0, '0, RADIUS_RST, MAX_LEVEL_RST);
                1: set_field($urandom, $urandom, $urandom, 5'd30, 5'd1);
                2: set_field(TOP_POS, BOTTOM_NEG, '0, 5'd0, 5'd16);
                3: set_field($urandom, $urandom, $urandom, 5'd31, 5'd31);
                4: set_field($urandom, $urandom, $urandom, 5'd12, 5'd5);
                5: set_field('0, '0, '0, 5'd30, 5'd16);
                default: set_field($urandom, $urandom, $urandom, 5'd16, 5'd8);
            endcase
            for (int i = 0; i < PER_PHASE; i++)
            begin
                if (random_n < PHASES * PER_PHASE / 3)
                begin
                    tx_idle = 22;
                    rx_idle = 79;
                end
                else if (random_n < 2 * PHASES * PER_PHASE / 3)
                begin
                    tx_idle = 79;
                    rx_idle = 22;
                end
                else
                begin
                    tx_idle = 0;
                    rx_idle = 0;
                end
                random_request(p == 5);
                random_n++;
            end
        end

        wait_idle();
        drained <= 1'b1;
        repeat (2) @(negedge clk);
        $display("Covered %0d requests (%0d occupy, %0d query) under %0d field settings.",
                 sent_n, occupy_n, query_n, settings_n);
        $display("Checked %0d results, %0d of them reporting an exhausted node pool.",
                 got_n, full_n);
        if (fault_count == 0)
        begin
            $display("octree_occupancy_insert_query_test: done, clean");
        end
        else
        begin
            $display("octree_occupancy_insert_query_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ocq_pkg.sv
rtl/ocq_ram.sv
rtl/ocq_ctrl.sv
rtl/ocq_dpath.sv
rtl/octree_occupancy_insert_query.sv
test/ocq_test_pkg.sv
test/octree_occupancy_insert_query_check.sv
test/octree_occupancy_insert_query_test.sv
